// ===== hdl/dpc_pkg.sv =====
// Shared types and constants for the detection to position covariance block.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
package dpc_pkg;

  localparam int ROOT_STAGES = 32;
  localparam int DIV_STAGES  = 32;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_VERT = 1'b0,
    CFG_HORZ = 1'b1
  } dpc_cfg_e;

  localparam logic [15:0] COEFF_RESET = 16'd4096;
  localparam logic [47:0] COV_ONE     = 48'd65536;

  // Row and column of each covariance element xx, xy, xz, yy, yz, zz.
  localparam int unsigned CI [6] = '{0, 0, 0, 1, 1, 2};
  localparam int unsigned CJ [6] = '{0, 1, 2, 1, 2, 2};

  // Data that travels alongside a request through the pipeline.
  typedef struct packed {
    logic             direct;
    logic             zero;
    logic [2:0][31:0] pt;
    logic [2:0][15:0] dmag;
    logic [2:0]       dneg;
    logic [31:0]      range;
  } dpc_side_t;

  typedef struct packed {
    dpc_side_t   side;
    logic [31:0] n2;
  } dpc_item_t;

  typedef struct packed {
    dpc_side_t   side;
    logic [31:0] s;
  } dpc_root_t;

  typedef struct packed {
    dpc_side_t        side;
    logic [2:0][30:0] umag;
  } dpc_unit_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [5:0][47:0] cov;
    logic             zero;
  } dpc_result_t;

endpackage

// ===== hdl/dpc_front.sv =====
// Front end: takes detection requests, forms direction magnitudes and |d|^2.
// Depends on dpc_pkg.
`timescale 1ns / 1ps
module dpc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  input  logic signed [31:0]  point_x_i,
  input  logic signed [31:0]  point_y_i,
  input  logic signed [31:0]  point_z_i,
  input  logic signed [15:0]  dir_x_i,
  input  logic signed [15:0]  dir_y_i,
  input  logic signed [15:0]  dir_z_i,
  input  logic [31:0]         range_m_i,
  input  logic                full_i,
  output logic                push_o,
  output dpc_pkg::dpc_item_t  item_o
);
  import dpc_pkg::*;

  logic       valid_q;
  dpc_side_t  side_q, side_d;
  logic [2:0][15:0] dir_in;
  logic [33:0] n2_sum;
  logic        accept;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = valid_q && full_i;
  assign push_o     = valid_q && !full_i;

  // Split the direction into sign and magnitude on the way in.
  assign dir_in = {dir_z_i, dir_y_i, dir_x_i};
  always_comb begin
    side_d        = '0;
    side_d.direct = req_type_i;
    side_d.pt     = {point_z_i, point_y_i, point_x_i};
    side_d.range  = range_m_i;
    for (int i = 0; i < 3; i++) begin
      side_d.dneg[i] = dir_in[i][15];
      side_d.dmag[i] = dir_in[i][15] ? 16'(-dir_in[i]) : dir_in[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      side_q <= side_d;
    end
  end

  // Squared length of the direction; an all-zero direction is flagged here unless the request is direct.
  assign n2_sum = 34'(side_q.dmag[0] * side_q.dmag[0]) + 34'(side_q.dmag[1] * side_q.dmag[1])
                + 34'(side_q.dmag[2] * side_q.dmag[2]);

  always_comb begin
    item_o           = '0;
    item_o.side      = side_q;
    item_o.n2        = n2_sum[31:0];
    item_o.side.zero = !side_q.direct && (n2_sum == '0);
  end

endmodule

// ===== hdl/dpc_queue.sv =====
// Short request queue between the front end and the arithmetic pipeline.
// Depends on dpc_pkg.
`timescale 1ns / 1ps
module dpc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  dpc_pkg::dpc_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output dpc_pkg::dpc_item_t item_o
);
  import dpc_pkg::*;

  dpc_item_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, rd_q;
  logic [QCNT_W-1:0]   cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ===== hdl/dpc_root.sv =====
// Pipelined square root: s = floor(sqrt(n2 * 2^32)), one result bit a stage.
// Depends on dpc_pkg.
`timescale 1ns / 1ps
module dpc_root (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  dpc_pkg::dpc_item_t item_i,
  output logic               valid_o,
  output dpc_pkg::dpc_root_t root_o
);
  import dpc_pkg::*;

  typedef struct packed {
    logic [35:0] rem;
    logic [31:0] root;
    logic [63:0] x;
  } rs_t;

  logic [ROOT_STAGES-1:0] vld_q;
  rs_t                    st_q   [ROOT_STAGES];
  dpc_side_t              side_q [ROOT_STAGES];
  rs_t                    st_in;

  function automatic rs_t root_step(rs_t a);
    rs_t         r;
    logic [35:0] cur;
    logic [35:0] trial;
    cur   = {a.rem[33:0], a.x[63:62]};
    trial = {2'b00, a.root, 2'b01};
    r.x   = {a.x[61:0], 2'b00};
    if (cur >= trial) begin
      r.rem  = cur - trial;
      r.root = {a.root[30:0], 1'b1};
    end else begin
      r.rem  = cur;
      r.root = {a.root[30:0], 1'b0};
    end
    return r;
  endfunction

  assign st_in = '{rem: '0, root: '0, x: {item_i.n2, 32'd0}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[ROOT_STAGES-2:0], valid_i};
    end
  end

  // Each stage settles one bit of the root.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      st_q[0]   <= root_step(st_in);
      side_q[0] <= item_i.side;
      for (int k = 1; k < ROOT_STAGES; k++) begin
        st_q[k]   <= root_step(st_q[k-1]);
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o     = vld_q[ROOT_STAGES-1];
  assign root_o.side = side_q[ROOT_STAGES-1];
  assign root_o.s    = st_q[ROOT_STAGES-1].root;

endmodule

// ===== hdl/dpc_div.sv =====
// Pipelined restoring division giving the unit vector magnitudes in unsigned Q1.30, rounded.
// Depends on dpc_pkg.
`timescale 1ns / 1ps
module dpc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  dpc_pkg::dpc_root_t root_i,
  output logic               valid_o,
  output dpc_pkg::dpc_unit_t unit_o
);
  import dpc_pkg::*;

  typedef struct packed {
    logic [31:0]      s;
    logic [2:0][31:0] r;
    logic [2:0][30:0] lo;
    logic [2:0][30:0] q;
  } ds_t;

  logic [DIV_STAGES-1:0] vld_q;
  ds_t                   st_q   [DIV_STAGES];
  dpc_side_t             side_q [DIV_STAGES];
  ds_t                   st_in;
  logic [2:0][61:0]      num;

  function automatic ds_t div_step(ds_t a);
    ds_t         r;
    logic [32:0] cur;
    r = a;
    for (int i = 0; i < 3; i++) begin
      cur     = {a.r[i], a.lo[i][30]};
      r.lo[i] = {a.lo[i][29:0], 1'b0};
      if (cur >= {1'b0, a.s}) begin
        r.r[i] = 32'(cur - {1'b0, a.s});
        r.q[i] = {a.q[i][29:0], 1'b1};
      end else begin
        r.r[i] = cur[31:0];
        r.q[i] = {a.q[i][29:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Numerator |d| * 2^46 + s/2 for round to nearest.
  always_comb begin
    st_in   = '0;
    st_in.s = root_i.s;
    for (int i = 0; i < 3; i++) begin
      num[i]      = {root_i.side.dmag[i], 46'd0} + 62'(root_i.s[31:1]);
      st_in.r[i]  = {1'b0, num[i][61:31]};
      st_in.lo[i] = num[i][30:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[DIV_STAGES-2:0], valid_i};
    end
  end

  // The first stage loads the numerator, each later one settles a quotient bit.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      st_q[0]   <= st_in;
      side_q[0] <= root_i.side;
      for (int k = 1; k < DIV_STAGES; k++) begin
        st_q[k]   <= div_step(st_q[k-1]);
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o     = vld_q[DIV_STAGES-1];
  assign unit_o.side = side_q[DIV_STAGES-1];
  assign unit_o.umag = st_q[DIV_STAGES-1].q;

endmodule

// ===== hdl/dpc_back.sv =====
// Back end: position offset, covariance products, rounding and output register.
// Depends on dpc_pkg.
`timescale 1ns / 1ps
module dpc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  dpc_pkg::dpc_unit_t   unit_i,
  input  logic [15:0]          vert_i,
  input  logic [15:0]          horz_i,
  input  logic                 out_stall_i,
  output logic                 adv_o,
  output logic                 out_valid_o,
  output dpc_pkg::dpc_result_t res_o
);
  import dpc_pkg::*;

  logic [3:0]  vld_q;
  logic        out_valid_q;
  dpc_side_t   side_q [4];

  // Stage one: raw products.
  logic [2:0][30:0] ue;
  logic [2:0][62:0] pu_q;
  logic [5:0][61:0] pp_q;
  logic [5:0]       pneg_q;
  logic [2:0]       uneg_q;
  // Stage two: positions and rounded outer product.
  logic [2:0][31:0] pos2_q;
  logic [5:0][31:0] p_q;
  // Stage three: covariance kernel.
  logic [2:0][31:0] pos3_q;
  logic [5:0][48:0] k_q;
  // Stage four: kernel times range, split in two halves.
  logic [2:0][31:0] pos4_q;
  logic [5:0][55:0] klo_q, khi_q;
  logic [5:0]       kneg_q;
  dpc_result_t      res_q;

  logic signed [16:0] dvh;

  assign adv_o       = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;
  assign dvh         = $signed({1'b0, vert_i}) - $signed({1'b0, horz_i});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ue[i] = unit_i.side.zero ? '0 : unit_i.umag[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      vld_q       <= {vld_q[2:0], valid_i};
      out_valid_q <= vld_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [63:0]        off_sum;
    logic [33:0]        off;
    logic signed [33:0] psum;
    logic [62:0]        pm_sum;
    logic [31:0]        pm;
    logic signed [48:0] prod;
    logic [48:0]        kabs;
    logic [79:0]        tot;
    logic [47:0]        c;
    if (adv_o) begin
      // Stage one.
      side_q[0] <= unit_i.side;
      for (int i = 0; i < 3; i++) begin
        pu_q[i]   <= ue[i] * unit_i.side.range;
        uneg_q[i] <= unit_i.side.dneg[i];
      end
      for (int j = 0; j < 6; j++) begin
        pp_q[j]   <= ue[CI[j]] * ue[CJ[j]];
        pneg_q[j] <= unit_i.side.dneg[CI[j]] ^ unit_i.side.dneg[CJ[j]];
      end

      // Stage two: round, offset the sensor point and saturate.
      side_q[1] <= side_q[0];
      for (int i = 0; i < 3; i++) begin
        off_sum = {1'b0, pu_q[i]} + 64'(1 << 29);
        off     = off_sum[63:30];
        psum    = $signed({{2{side_q[0].pt[i][31]}}, side_q[0].pt[i]})
                + (uneg_q[i] ? -$signed(off) : $signed(off));
        if (psum > 34'sd2147483647) begin
          pos2_q[i] <= 32'h7fff_ffff;
        end else if (psum < -34'sd2147483648) begin
          pos2_q[i] <= 32'h8000_0000;
        end else begin
          pos2_q[i] <= psum[31:0];
        end
      end
      for (int j = 0; j < 6; j++) begin
        pm_sum  = {1'b0, pp_q[j]} + 63'(1 << 29);
        pm      = {1'b0, pm_sum[60:30]};
        p_q[j] <= pneg_q[j] ? -pm : pm;
      end

      // Stage three: k = (v - h) * p, plus h on the diagonal.
      side_q[2] <= side_q[1];
      pos3_q    <= pos2_q;
      for (int j = 0; j < 6; j++) begin
        prod = dvh * $signed(p_q[j]);
        if (CI[j] == CJ[j]) begin
          k_q[j] <= prod + $signed({3'b000, horz_i, 30'd0});
        end else begin
          k_q[j] <= prod;
        end
      end

      // Stage four: |k| times range in two partial products.
      side_q[3] <= side_q[2];
      pos4_q    <= pos3_q;
      for (int j = 0; j < 6; j++) begin
        kabs       = k_q[j][48] ? -k_q[j] : k_q[j];
        kneg_q[j] <= k_q[j][48];
        klo_q[j]  <= kabs[23:0] * side_q[2].range;
        khi_q[j]  <= kabs[47:24] * side_q[2].range;
      end

      // Output register: sum, round, sign, and the direct-mode override.
      for (int j = 0; j < 6; j++) begin
        tot = {24'd0, klo_q[j]} + {khi_q[j], 24'd0} + 80'(64'd1 << 41);
        c   = {10'd0, tot[79:42]};
        if (side_q[3].direct) begin
          res_q.cov[j] <= (CI[j] == CJ[j]) ? COV_ONE : '0;
        end else begin
          res_q.cov[j] <= kneg_q[j] ? -c : c;
        end
      end
      res_q.pos  <= side_q[3].direct ? side_q[3].pt : pos4_q;
      res_q.zero <= side_q[3].zero;
    end
  end

endmodule

// ===== hdl/detection_to_position_covariance.sv =====
// Top level of the detection to position covariance converter.
// Depends on dpc_pkg, dpc_front, dpc_queue, dpc_root, dpc_div and dpc_back.
//
//  Channel  Handshake                  Payload
//  in       in_valid_i / in_stall_o    req_type, point_x/y/z, dir_x/y/z, range_m
//  out      out_valid_o / out_stall_i  pos_x/y/z, cov_xx..cov_zz, zero_direction
//  cfg      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// One request is taken per clock cycle when the output is not stalled.
// Without stalls, an accepted request passes, in order, the front-end register, which
// loads at the accepting edge, a queue entry, the square-root stages, the divider
// stages and the back-end stages with the output register before a valid result.
// Reset clears all valid state; the coefficients return to 1.0.
// An output stall freezes the whole arithmetic pipeline; the two-entry queue
// lets the front end keep taking requests until the queue is full.
`timescale 1ns / 1ps
module detection_to_position_covariance (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic signed [15:0] dir_z_i,
  input  logic [31:0]        range_m_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [47:0] cov_xx_o,
  output logic signed [47:0] cov_xy_o,
  output logic signed [47:0] cov_xz_o,
  output logic signed [47:0] cov_yy_o,
  output logic signed [47:0] cov_yz_o,
  output logic signed [47:0] cov_zz_o,
  output logic               zero_direction_o,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);
  import dpc_pkg::*;

  logic [15:0] vert_coeff_q, horz_coeff_q;
  logic        push, q_full, q_empty, pop, adv;
  dpc_item_t   front_item, q_item;
  logic        root_valid, div_valid;
  dpc_root_t   root_res;
  dpc_unit_t   unit_res;
  dpc_result_t res;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vert_coeff_q <= COEFF_RESET;
      horz_coeff_q <= COEFF_RESET;
    end else if (cfg_we_i) begin
      case (dpc_cfg_e'(cfg_idx_i))
        CFG_VERT: vert_coeff_q <= cfg_data_i;
        CFG_HORZ: horz_coeff_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dpc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i,
    .point_x_i, .point_y_i, .point_z_i, .dir_x_i, .dir_y_i, .dir_z_i, .range_m_i,
    .full_i (q_full),
    .push_o (push),
    .item_o (front_item)
  );

  assign pop = adv && !q_empty;

  dpc_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .item_o  (q_item)
  );

  dpc_root u_root (
    .clk_i, .rst_ni,
    .adv_i   (adv),
    .valid_i (pop),
    .item_i  (q_item),
    .valid_o (root_valid),
    .root_o  (root_res)
  );

  dpc_div u_div (
    .clk_i, .rst_ni,
    .adv_i   (adv),
    .valid_i (root_valid),
    .root_i  (root_res),
    .valid_o (div_valid),
    .unit_o  (unit_res)
  );

  dpc_back u_back (
    .clk_i, .rst_ni,
    .valid_i     (div_valid),
    .unit_i      (unit_res),
    .vert_i      (vert_coeff_q),
    .horz_i      (horz_coeff_q),
    .out_stall_i,
    .adv_o       (adv),
    .out_valid_o,
    .res_o       (res)
  );

  assign pos_x_o          = res.pos[0];
  assign pos_y_o          = res.pos[1];
  assign pos_z_o          = res.pos[2];
  assign cov_xx_o         = res.cov[0];
  assign cov_xy_o         = res.cov[1];
  assign cov_xz_o         = res.cov[2];
  assign cov_yy_o         = res.cov[3];
  assign cov_yz_o         = res.cov[4];
  assign cov_zz_o         = res.cov[5];
  assign zero_direction_o = res.zero;

  // The queue cannot be full and empty at once.
  a_queue_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_full && q_empty))
    else $error("queue reports full and empty together");

  // A zero direction leaves no cross terms in the covariance.
  a_zero_offdiag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_direction_o |-> cov_xy_o == '0 && cov_xz_o == '0 && cov_yz_o == '0)
    else $error("cross covariance non-zero for a zero direction");

  // A zero direction gives an isotropic covariance.
  a_zero_iso: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_direction_o |-> cov_xx_o == cov_yy_o && cov_yy_o == cov_zz_o)
    else $error("diagonal differs for a zero direction");

  // A popped request always enters the pipeline while it advances.
  a_pop_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> adv)
    else $error("queue popped while the pipeline is frozen");

endmodule
